/* design/ukt_pkg.sv */
// ---------------------------------------------------------------------------
// ukt_pkg
// Shared types and constants for the unordered key table.
// ---------------------------------------------------------------------------
`default_nettype none

package ukt_pkg;

  localparam int KEY_W   = 32;
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 4;
  localparam int ECNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_SLOT  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_RM_READ,
    S_RM_WRITE,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    latch;       // capture the input fields
    logic    scan_start;  // reset scan pointers
    logic    scan_step;   // issue next scan read, retire previous
    logic    capture_hit; // record slot of current compare
    logic    ram_we;
    logic    wr_remove;   // write moved entry into removed slot
    logic    rd_last;     // read address is the last stored entry
    logic    count_inc;
    logic    count_dec;
    logic    out_load;
    status_t res_code;
  } ukt_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic slot_ok;
    logic match;
    logic scan_done;
  } ukt_sts_t;

endpackage

`default_nettype wire

/* design/ukt_ram.sv */
// ---------------------------------------------------------------------------
// ukt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ukt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/ukt_ctrl.sv */
// ---------------------------------------------------------------------------
// ukt_ctrl
// Command sequencer: decodes a transaction and steps the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module ukt_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [ukt_pkg::CMD_W-1:0]  cmd,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  input  wire ukt_pkg::ukt_sts_t          sts,
  output ukt_pkg::ukt_ctl_t               ctl
);

  ukt_pkg::state_t  state, state_next;
  ukt_pkg::status_t res_code, res_code_next;
  logic             out_valid_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ukt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_code <= res_code_next;
  end

  always_comb begin
    state_next     = state;
    res_code_next  = res_code;
    out_valid_next = out_valid && out_stall;
    in_stall       = 1'b1;
    ctl            = '0;
    ctl.res_code   = res_code;

    unique case (state)
      ukt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.latch = 1'b1;
          unique case (ukt_pkg::cmd_t'(cmd))
            ukt_pkg::CMD_INSERT: state_next = ukt_pkg::S_INSERT;
            ukt_pkg::CMD_SEARCH: begin
              ctl.scan_start = 1'b1;
              state_next     = ukt_pkg::S_SCAN;
            end
            ukt_pkg::CMD_REMOVE: state_next = ukt_pkg::S_RM_READ;
            default: begin
              res_code_next = ukt_pkg::ST_OK;
              state_next    = ukt_pkg::S_FINISH;
            end
          endcase
        end
      end
      ukt_pkg::S_INSERT: begin
        if (sts.full) begin
          res_code_next = ukt_pkg::ST_FULL;
        end else begin
          ctl.ram_we    = 1'b1;
          ctl.count_inc = 1'b1;
          res_code_next = ukt_pkg::ST_OK;
        end
        state_next = ukt_pkg::S_FINISH;
      end
      ukt_pkg::S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.match) begin
          ctl.capture_hit = 1'b1;
          res_code_next   = ukt_pkg::ST_OK;
          state_next      = ukt_pkg::S_FINISH;
        end else if (sts.scan_done) begin
          res_code_next = ukt_pkg::ST_NOT_FOUND;
          state_next    = ukt_pkg::S_FINISH;
        end
      end
      ukt_pkg::S_RM_READ: begin
        ctl.rd_last = 1'b1;
        if (sts.slot_ok) begin
          state_next = ukt_pkg::S_RM_WRITE;
        end else begin
          res_code_next = ukt_pkg::ST_BAD_SLOT;
          state_next    = ukt_pkg::S_FINISH;
        end
      end
      ukt_pkg::S_RM_WRITE: begin
        ctl.ram_we    = 1'b1;
        ctl.wr_remove = 1'b1;
        ctl.count_dec = 1'b1;
        res_code_next = ukt_pkg::ST_OK;
        state_next    = ukt_pkg::S_FINISH;
      end
      ukt_pkg::S_FINISH: begin
        if (out_free) begin
          ctl.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ukt_pkg::S_IDLE;
        end
      end
      default: state_next = ukt_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* design/ukt_dp.sv */
// ---------------------------------------------------------------------------
// ukt_dp
// Datapath: key store, entry count, scan pointers and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module ukt_dp #(
  parameter int CAPACITY = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ukt_pkg::ukt_ctl_t            ctl,
  output ukt_pkg::ukt_sts_t                 sts,
  input  wire logic [ukt_pkg::KEY_W-1:0]    in_key,
  input  wire logic [ukt_pkg::SLOT_W-1:0]   in_slot,
  output logic      [ukt_pkg::STAT_W-1:0]   status,
  output logic      [ukt_pkg::FOUND_W-1:0]  found_slot,
  output logic      [ukt_pkg::ECNT_W-1:0]   entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [ukt_pkg::KEY_W-1:0]  key_q;
  logic [ukt_pkg::SLOT_W-1:0] slot_q;
  logic [CW-1:0]              count;
  logic [CW-1:0]              scan_idx;
  logic                       rd_pend;
  logic [AW-1:0]              rd_idx;
  logic [AW-1:0]              hit_slot;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ukt_pkg::KEY_W-1:0]  ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [ukt_pkg::KEY_W-1:0]  ram_rdata;
  logic                       scan_more;

  assign scan_more = scan_idx < count;

  always_comb begin
    sts.full      = count == CW'(CAPACITY);
    sts.slot_ok   = 32'(slot_q) < 32'(count);
    sts.match     = rd_pend && (ram_rdata == key_q);
    sts.scan_done = !rd_pend && !scan_more;
  end

  assign ram_we    = ctl.ram_we;
  assign ram_waddr = ctl.wr_remove ? AW'(slot_q) : AW'(count);
  assign ram_wdata = ctl.wr_remove ? ram_rdata : key_q;
  assign ram_raddr = ctl.rd_last ? AW'(count - CW'(1)) : AW'(scan_idx);

  ukt_ram #(
    .WIDTH (ukt_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (ctl.count_inc) begin
        count <= count + CW'(1);
      end else if (ctl.count_dec) begin
        count <= count - CW'(1);
      end
      if (ctl.scan_start) begin
        rd_pend <= 1'b0;
      end else if (ctl.scan_step) begin
        rd_pend <= scan_more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      key_q    <= in_key;
      slot_q   <= in_slot;
      hit_slot <= '0;
    end
    if (ctl.scan_start) begin
      scan_idx <= '0;
    end else if (ctl.scan_step && scan_more) begin
      scan_idx <= scan_idx + CW'(1);
      rd_idx   <= AW'(scan_idx);
    end
    if (ctl.capture_hit) begin
      hit_slot <= rd_idx;
    end
    if (ctl.out_load) begin
      status      <= ctl.res_code;
      found_slot  <= ukt_pkg::FOUND_W'(hit_slot);
      entry_count <= ukt_pkg::ECNT_W'(count);
    end
  end

endmodule

`default_nettype wire

/* design/unordered_key_table.sv */
// ---------------------------------------------------------------------------
// unordered_key_table
// Fixed-capacity unordered table of 32-bit keys: insert, search, remove.
// ---------------------------------------------------------------------------
// One transaction in gives exactly one result transaction out. Insert appends
// the key behind the stored entries (status full when the table holds
// CAPACITY keys). Search scans slots from 0 upward and returns the first slot
// holding the key, or status not-found. Remove at a slot below the count moves
// the last entry into that slot and drops the count; otherwise it reports a
// bad slot. Command code 3 does nothing and reports ok. Every result carries
// the count after the command; found_slot wraps to its port width when
// CAPACITY exceeds 16, and entry_count when CAPACITY exceeds 31. The block
// works on one transaction at a time. A search ends at the first match or
// after the last stored entry: the keys live in one RAM with a single
// registered read port, and the scan reads one entry per cycle through it.
// A finished result sits in an output register, so the next command is
// accepted while it waits to be taken.
// There is no clearing pass after reset; the count bounds every read.
// ---------------------------------------------------------------------------
`default_nettype none

module unordered_key_table #(
  parameter int CAPACITY = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // command channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ukt_pkg::CMD_W-1:0]    cmd,
  input  wire logic signed [ukt_pkg::KEY_W-1:0] key,
  input  wire logic [ukt_pkg::SLOT_W-1:0]   slot_index,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [ukt_pkg::STAT_W-1:0]   status,
  output logic      [ukt_pkg::FOUND_W-1:0]  found_slot,
  output logic      [ukt_pkg::ECNT_W-1:0]   entry_count
);

  ukt_pkg::ukt_ctl_t ctl;
  ukt_pkg::ukt_sts_t sts;

  // Sequencer: decode the command, walk the scan, hold the result until taken.
  ukt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Datapath: key RAM, count, scan pointers and output registers.
  ukt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .in_key      (key),
    .in_slot     (slot_index),
    .status      (status),
    .found_slot  (found_slot),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire

/* design/ukt_checker.sv */
// ---------------------------------------------------------------------------
// ukt_checker
// Port-level checks for the unordered key table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ukt_checker #(
  parameter int CAPACITY = 16
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [ukt_pkg::STAT_W-1:0]   status,
  input wire logic [ukt_pkg::FOUND_W-1:0]  found_slot,
  input wire logic [ukt_pkg::ECNT_W-1:0]   entry_count
);

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_slot)
      && $stable(entry_count))
    else $error("result changed while stalled");

  // Only a successful search reports a nonzero slot.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ukt_pkg::ST_OK |-> found_slot == '0)
    else $error("found_slot set on failing command");

  // A full report means the count sits at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ukt_pkg::ST_FULL |-> entry_count == ukt_pkg::ECNT_W'(CAPACITY))
    else $error("full reported below capacity");

  // Count never exceeds capacity where the port can show it.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY > 31) || (32'(entry_count) <= 32'(CAPACITY)))
    else $error("entry_count above capacity");

endmodule

bind unordered_key_table ukt_checker #(
  .CAPACITY (CAPACITY)
) u_ukt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .found_slot  (found_slot),
  .entry_count (entry_count)
);

`default_nettype wire
